// ===== src/bdcc_pkg.sv =====
// Shared types and constants for the button debounce and click classifier.
package bdcc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned PIN_W  = 8;
    localparam int unsigned ID_W   = 3;
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_HOLD = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUTTONS  = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SHORT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LONG  = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] MIN_HOLD_RST = 16'd1000;

    typedef struct packed {
        logic sample;
        logic clear_act;
        logic wipe;
    } lane_ctrl_t;

    typedef struct packed {
        logic             level;
        logic [ACT_W-1:0] action;
    } lane_stat_t;

endpackage

// ===== src/bdcc_lane.sv =====
// One button lane: raw edge timing, debounced level and click latch.
module bdcc_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bdcc_pkg::lane_ctrl_t             ctrl,
    input  logic                             pin,
    input  logic [bdcc_pkg::TIME_W-1:0]      now_ms,
    input  logic [bdcc_pkg::CFG_W-1:0]       debounce_ms,
    input  logic [bdcc_pkg::CFG_W-1:0]       min_hold_ms,
    output bdcc_pkg::lane_stat_t             stat
);

    logic                           raw_prev_reg, raw_prev_next;
    logic [bdcc_pkg::TIME_W-1:0]    raw_time_reg, raw_time_next;
    logic                           level_reg, level_next;
    logic [bdcc_pkg::TIME_W-1:0]    off_time_reg, off_time_next;
    logic [bdcc_pkg::ACT_W-1:0]     action_reg, action_next;

    logic                           changed;
    logic                           flip;
    logic                           is_long;
    logic [bdcc_pkg::TIME_W-1:0]    since_raw;
    logic [bdcc_pkg::TIME_W-1:0]    held;

    always_comb begin
        changed   = (pin != raw_prev_reg);
        since_raw = now_ms - raw_time_reg;
        held      = now_ms - off_time_reg;
        // a sample that carries a fresh raw edge can never settle the level
        flip      = !changed
                    && (since_raw > bdcc_pkg::TIME_W'(debounce_ms))
                    && (pin != level_reg);
        is_long   = (held >= bdcc_pkg::TIME_W'(min_hold_ms));

        raw_prev_next = raw_prev_reg;
        raw_time_next = raw_time_reg;
        level_next    = level_reg;
        off_time_next = off_time_reg;
        action_next   = action_reg;

        if (ctrl.sample) begin
            raw_prev_next = pin;
            if (changed) begin
                raw_time_next = now_ms;
            end
            if (flip) begin
                level_next    = pin;
                off_time_next = now_ms;
                if (pin) begin
                    action_next = is_long ? bdcc_pkg::ACT_LONG : bdcc_pkg::ACT_SHORT;
                end
            end
        end
        if (ctrl.clear_act) begin
            action_next = bdcc_pkg::ACT_NONE;
        end

        stat.level  = level_next;
        stat.action = action_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.wipe) begin
            raw_prev_reg <= 1'b1;
            raw_time_reg <= '0;
            level_reg    <= 1'b1;
            off_time_reg <= '0;
            action_reg   <= bdcc_pkg::ACT_NONE;
        end else begin
            raw_prev_reg <= raw_prev_next;
            raw_time_reg <= raw_time_next;
            level_reg    <= level_next;
            off_time_reg <= off_time_next;
            action_reg   <= action_next;
        end
    end

endmodule

// ===== src/bdcc_merge.sv =====
// Merges the lane states into one result and holds it in the output register.
module bdcc_merge #(
    parameter int unsigned NBUTTONS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic                                 out_ready,
    input  bdcc_pkg::lane_stat_t [NBUTTONS-1:0]  stat,
    output logic                                 in_ready,
    output logic                                 out_valid,
    output logic [2*bdcc_pkg::PIN_W-1:0]         out_actions,
    output logic [bdcc_pkg::PIN_W-1:0]           out_levels
);

    logic [2*bdcc_pkg::PIN_W-1:0] pack_act;
    logic [bdcc_pkg::PIN_W-1:0]   pack_lvl;

    logic                         valid_reg, valid_next;
    logic [2*bdcc_pkg::PIN_W-1:0] actions_reg;
    logic [bdcc_pkg::PIN_W-1:0]   levels_reg;

    genvar g;
    generate
        for (g = 0; g < bdcc_pkg::PIN_W; g++) begin : g_pack
            if (g < NBUTTONS) begin : g_shown
                assign pack_act[2*g +: 2] = stat[g].action;
                assign pack_lvl[g]        = stat[g].level;
            end else begin : g_absent
                assign pack_act[2*g +: 2] = bdcc_pkg::ACT_NONE;
                assign pack_lvl[g]        = 1'b0;
            end
        end
    endgenerate

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            actions_reg <= pack_act;
            levels_reg  <= pack_lvl;
        end
    end

    assign out_valid   = valid_reg;
    assign out_actions = actions_reg;
    assign out_levels  = levels_reg;

endmodule

// ===== src/button_debounce_click_classifier.sv =====
// Top level: configuration registers, lane array and result merge.
//
//  channel   direction  handshake          contents
//  s_*       in         s_valid/s_ready    func, now_ms, pin_levels, button_id
//  m_*       out        m_valid/m_ready    actions, debounced_levels
//  cfg_*     in         cfg_we             cfg_idx, cfg_wdata
//
//  One request per cycle while m_ready drains the held result; every request gives its result in the next cycle.
//  All active lanes update in parallel within the accepting cycle; the output
//  register holds the merged result.
//  A request is taken while the held result leaves in the same cycle.
//  Synchronous active-low reset; no clearing sweep after reset.
module button_debounce_click_classifier #(
    parameter int unsigned NBUTTONS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bdcc_pkg::IDX_W-1:0]       cfg_idx,
    input  logic [bdcc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [bdcc_pkg::TIME_W-1:0]      s_now_ms,
    input  logic [bdcc_pkg::PIN_W-1:0]       s_pin_levels,
    input  logic [bdcc_pkg::ID_W-1:0]        s_button_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2*bdcc_pkg::PIN_W-1:0]     m_actions,
    output logic [bdcc_pkg::PIN_W-1:0]       m_debounced_levels
);

    localparam int unsigned NCW  = $clog2(NBUTTONS + 1);
    localparam int unsigned CMPW = (NCW > bdcc_pkg::CNT_W) ? NCW : bdcc_pkg::CNT_W;

    logic [bdcc_pkg::CFG_W-1:0] debounce_reg, debounce_next;
    logic [bdcc_pkg::CFG_W-1:0] min_hold_reg, min_hold_next;
    logic [bdcc_pkg::CNT_W-1:0] buttons_reg, buttons_next;

    logic            accept;
    logic            cnt_write;
    logic [CMPW-1:0] n_active;
    logic [CMPW-1:0] n_new;
    logic [CMPW-1:0] cnt_cur;
    logic [CMPW-1:0] cnt_new;

    bdcc_pkg::lane_ctrl_t [NBUTTONS-1:0] lane_ctrl;
    bdcc_pkg::lane_stat_t [NBUTTONS-1:0] lane_stat;

    always_comb begin
        debounce_next = debounce_reg;
        min_hold_next = min_hold_reg;
        buttons_next  = buttons_reg;
        if (cfg_we) begin
            case (cfg_idx)
                bdcc_pkg::REG_DEBOUNCE: debounce_next = cfg_wdata;
                bdcc_pkg::REG_MIN_HOLD: min_hold_next = cfg_wdata;
                bdcc_pkg::REG_BUTTONS:  buttons_next  = cfg_wdata[bdcc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdcc_pkg::DEBOUNCE_RST;
            min_hold_reg <= bdcc_pkg::MIN_HOLD_RST;
            buttons_reg  <= '0;
        end else begin
            debounce_reg <= debounce_next;
            min_hold_reg <= min_hold_next;
            buttons_reg  <= buttons_next;
        end
    end

    // lane count saturates at NBUTTONS
    assign cnt_cur   = CMPW'(buttons_reg);
    assign cnt_new   = CMPW'(cfg_wdata[bdcc_pkg::CNT_W-1:0]);
    assign n_active  = (cnt_cur > CMPW'(NBUTTONS)) ? CMPW'(NBUTTONS) : cnt_cur;
    assign n_new     = (cnt_new > CMPW'(NBUTTONS)) ? CMPW'(NBUTTONS) : cnt_new;
    assign cnt_write = cfg_we && (cfg_idx == bdcc_pkg::REG_BUTTONS);
    assign accept    = s_valid && s_ready;

    genvar g;
    generate
        for (g = 0; g < NBUTTONS; g++) begin : g_lane
            logic lane_pin;

            if (g < bdcc_pkg::PIN_W) begin : g_pin
                assign lane_pin = s_pin_levels[g];
            end else begin : g_nopin
                assign lane_pin = 1'b1;
            end

            assign lane_ctrl[g].sample    = accept && (s_func == bdcc_pkg::FUNC_SAMPLE)
                                            && (CMPW'(g) < n_active);
            assign lane_ctrl[g].clear_act = accept && (s_func == bdcc_pkg::FUNC_CLEAR)
                                            && (CMPW'(s_button_id) == CMPW'(g));
            assign lane_ctrl[g].wipe      = cnt_write && (CMPW'(g) >= n_new);

            bdcc_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (lane_ctrl[g]),
                .pin         (lane_pin),
                .now_ms      (s_now_ms),
                .debounce_ms (debounce_reg),
                .min_hold_ms (min_hold_reg),
                .stat        (lane_stat[g])
            );
        end
    endgenerate

    bdcc_merge #(
        .NBUTTONS (NBUTTONS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .out_ready   (m_ready),
        .stat        (lane_stat),
        .in_ready    (s_ready),
        .out_valid   (m_valid),
        .out_actions (m_actions),
        .out_levels  (m_debounced_levels)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while result stalled");

    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_actions & (m_actions >> 1) & 16'h5555) == 16'h0000))
        else $error("undefined click code");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == bdcc_pkg::FUNC_CLEAR))
        |=> (((m_actions >> (2 * $past(s_button_id))) & 16'h0003) == 16'h0000))
        else $error("cleared action still shown");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the button debounce and click classifier.
module testbench;

    localparam int NLANES = bdcc_pkg::PIN_W;
    localparam logic [bdcc_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                        func;
        logic [bdcc_pkg::TIME_W-1:0] now;
        logic [bdcc_pkg::PIN_W-1:0]  pins;
        logic [bdcc_pkg::ID_W-1:0]   id;
    } press_req_t;

    typedef struct packed {
        logic [2*bdcc_pkg::PIN_W-1:0] actions;
        logic [bdcc_pkg::PIN_W-1:0]   levels;
    } lane_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [bdcc_pkg::IDX_W-1:0] cfg_idx = '0;
    logic [bdcc_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = bdcc_pkg::FUNC_SAMPLE;
    logic [bdcc_pkg::TIME_W-1:0] s_now_ms = '0;
    logic [bdcc_pkg::PIN_W-1:0] s_pin_levels = '1;
    logic [bdcc_pkg::ID_W-1:0] s_button_id = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2*bdcc_pkg::PIN_W-1:0] m_actions;
    logic [bdcc_pkg::PIN_W-1:0] m_debounced_levels;

    button_debounce_click_classifier uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func(s_func),
        .s_now_ms(s_now_ms),
        .s_pin_levels(s_pin_levels),
        .s_button_id(s_button_id),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_actions(m_actions),
        .m_debounced_levels(m_debounced_levels)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [bdcc_pkg::CFG_W-1:0]  debounce_cfg;
    logic [bdcc_pkg::CFG_W-1:0]  min_hold_cfg;
    logic [bdcc_pkg::CNT_W-1:0]  lanes_cfg;
    logic                        raw_last    [NLANES];
    logic [bdcc_pkg::TIME_W-1:0] raw_edge_ms [NLANES];
    logic                        steady_lvl  [NLANES];
    logic [bdcc_pkg::TIME_W-1:0] steady_ms   [NLANES];
    logic [bdcc_pkg::ACT_W-1:0]  click       [NLANES];

    press_req_t   request_q [$];
    lane_report_t report_q [$];
    press_req_t   offered;
    lane_report_t want_rep;

    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold_go = 1'b0;
    logic rx_hold = 1'b0;
    int errors = 0;

    // stimulus generator state
    logic [bdcc_pkg::TIME_W-1:0] clock_ms = '0;
    logic [bdcc_pkg::PIN_W-1:0]  lane_goal = '1;
    logic [bdcc_pkg::PIN_W-1:0]  pin_now = '1;
    int bounce_left [NLANES];

    function automatic int unsigned lanes_active();
        return (lanes_cfg > NLANES) ? NLANES : lanes_cfg;
    endfunction

    function automatic void wipe_lane(input int i);
        raw_last[i] = 1'b1;
        raw_edge_ms[i] = '0;
        steady_lvl[i] = 1'b1;
        steady_ms[i] = '0;
        click[i] = bdcc_pkg::ACT_NONE;
    endfunction

    function automatic lane_report_t classify_request(input press_req_t r);
        lane_report_t rep;
        logic [bdcc_pkg::TIME_W-1:0] since;
        logic lvl;
        int i;
        if (r.func == bdcc_pkg::FUNC_SAMPLE) begin
            for (i = 0; i < lanes_active(); i++) begin
                lvl = r.pins[i];
                if (lvl != raw_last[i])
                    raw_edge_ms[i] = r.now;
                raw_last[i] = lvl;
                since = r.now - raw_edge_ms[i];
                if (since > {16'd0, debounce_cfg} && lvl != steady_lvl[i]) begin
                    steady_lvl[i] = lvl;
                    if (lvl) begin
                        since = r.now - steady_ms[i];
                        click[i] = (since < {16'd0, min_hold_cfg}) ? bdcc_pkg::ACT_SHORT
                                                                   : bdcc_pkg::ACT_LONG;
                    end
                    steady_ms[i] = r.now;
                end
            end
        end else begin
            click[r.id] = bdcc_pkg::ACT_NONE;
        end
        for (i = 0; i < NLANES; i++) begin
            rep.actions[2*i +: 2] = click[i];
            rep.levels[i] = steady_lvl[i];
        end
        return rep;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver: one request held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                report_q.push_back(classify_request(offered));
            if (!s_valid || s_ready) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = request_q.pop_front();
                    s_valid <= 1'b1;
                    s_func <= offered.func;
                    s_now_ms <= offered.now;
                    s_pin_levels <= offered.pins;
                    s_button_id <= offered.id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", 32'(m_actions), 0);
                end else begin
                    want_rep = report_q.pop_front();
                    if (m_actions !== want_rep.actions)
                        flag_mismatch("actions", 32'(m_actions), 32'(want_rep.actions));
                    if (m_debounced_levels !== want_rep.levels)
                        flag_mismatch("debounced_levels", 32'(m_debounced_levels),
                                      32'(want_rep.levels));
                end
            end
            m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        @(posedge rx_hold_go);
        rx_hold = 1'b1;
        repeat (300) @(negedge aclk);
        rx_hold = 1'b0;
    end

    task automatic write_reg(input logic [bdcc_pkg::IDX_W-1:0] idx,
                             input logic [bdcc_pkg::CFG_W-1:0] val);
        int i;
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        case (idx)
            bdcc_pkg::REG_DEBOUNCE: debounce_cfg = val;
            bdcc_pkg::REG_MIN_HOLD: min_hold_cfg = val;
            bdcc_pkg::REG_BUTTONS: begin
                lanes_cfg = val[bdcc_pkg::CNT_W-1:0];
                for (i = lanes_active(); i < NLANES; i++)
                    wipe_lane(i);
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (request_q.size() != 0 || s_valid || report_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic queue_sample(input logic [bdcc_pkg::TIME_W-1:0] now,
                                input logic [bdcc_pkg::PIN_W-1:0] pins);
        press_req_t r;
        r.func = bdcc_pkg::FUNC_SAMPLE;
        r.now = now;
        r.pins = pins;
        r.id = bdcc_pkg::ID_W'($urandom_range(7));
        request_q.push_back(r);
    endtask

    task automatic queue_clear(input logic [bdcc_pkg::ID_W-1:0] id);
        press_req_t r;
        r.func = bdcc_pkg::FUNC_CLEAR;
        r.now = $urandom;
        r.pins = bdcc_pkg::PIN_W'($urandom);
        r.id = id;
        request_q.push_back(r);
    endtask

    // press/release sequences with contact bounce, some clears and some noise
    task automatic queue_stream(input int n);
        int k, i;
        int unsigned step_max;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                queue_clear(bdcc_pkg::ID_W'($urandom_range(7)));
            end else begin
                step_max = debounce_cfg / 3 + 3;
                if ($urandom_range(29) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(1, step_max);
                for (i = 0; i < NLANES; i++) begin
                    if (bounce_left[i] > 0) begin
                        bounce_left[i]--;
                        pin_now[i] = 1'($urandom_range(1));
                    end else if ($urandom_range(7) == 0) begin
                        lane_goal[i] = ~lane_goal[i];
                        bounce_left[i] = $urandom_range(3);
                        pin_now[i] = (bounce_left[i] > 0) ? ~lane_goal[i] : lane_goal[i];
                    end else begin
                        pin_now[i] = lane_goal[i];
                    end
                end
                if ($urandom_range(19) == 0)
                    queue_sample(clock_ms, bdcc_pkg::PIN_W'($urandom));
                else
                    queue_sample(clock_ms, pin_now);
            end
        end
    endtask

    task automatic run_phase(input logic [bdcc_pkg::CFG_W-1:0] deb,
                             input logic [bdcc_pkg::CFG_W-1:0] hold,
                             input logic [bdcc_pkg::CNT_W-1:0] lanes, input int idle,
                             input int stall, input int n, input bit squeeze);
        write_reg(bdcc_pkg::REG_DEBOUNCE, deb);
        write_reg(bdcc_pkg::REG_MIN_HOLD, hold);
        write_reg(bdcc_pkg::REG_BUTTONS, bdcc_pkg::CFG_W'(lanes));
        @(negedge aclk);
        send_idle_pct = idle;
        rx_stall_pct = stall;
        if (squeeze)
            rx_hold_go = 1'b1;
        queue_stream(n);
        settle();
    endtask

    initial begin
        int p, i;
        int idle_opts [4];
        int stall_opts [4];
        logic [bdcc_pkg::CFG_W-1:0] deb;
        idle_opts = '{0, 59, 0, 27};
        stall_opts = '{0, 0, 59, 27};
        debounce_cfg = bdcc_pkg::DEBOUNCE_RST;
        min_hold_cfg = bdcc_pkg::MIN_HOLD_RST;
        lanes_cfg = '0;
        for (i = 0; i < NLANES; i++) begin
            wipe_lane(i);
            bounce_left[i] = 0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // no lanes in use after reset
        @(negedge aclk);
        queue_sample(32'd0, 8'h00);
        settle();
        write_reg(bdcc_pkg::REG_BUTTONS, 16'd8);
        @(negedge aclk);
        queue_sample(32'd1000, 8'h00);
        queue_sample(32'd1050, 8'h00);         // steady for exactly the debounce time
        queue_sample(32'd1051, 8'h00);
        queue_sample(32'd1100, 8'hFF);
        queue_sample(32'd1120, 8'h0F);         // bounce on the upper lanes
        queue_sample(32'd1130, 8'hFF);
        queue_sample(32'd1181, 8'hFF);         // short click
        queue_sample(32'd1200, 8'h00);
        queue_sample(32'd1251, 8'h00);         // press keeps the latched action
        queue_sample(32'd2251, 8'hFF);
        queue_sample(32'd2302, 8'hFF);         // long click
        queue_clear(3'd0);
        queue_clear(3'd7);
        queue_clear(3'd5);
        queue_sample(32'hFFFF_FFE0, 8'h00);    // timestamp wraps
        queue_sample(32'h0000_0020, 8'h00);
        queue_sample(32'h0000_0030, 8'hFF);
        queue_sample(32'h0000_0070, 8'hFF);
        queue_sample(32'd5000, 8'hFE);
        queue_sample(32'd5051, 8'hFE);
        queue_sample(32'd5990, 8'hFF);
        queue_sample(32'd6051, 8'hFF);         // held exactly the minimum: long
        queue_sample(32'hFFFF_FFFF, 8'h55);
        queue_clear(3'd3);
        settle();
        clock_ms = 32'hFFFF_F000;

        run_phase(16'd20, 16'd60, 4'd8, 0, 0, 60, 1'b0);
        run_phase(16'd0, 16'd0, 4'd15, 59, 0, 60, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 4'd8, 0, 59, 60, 1'b0);
        run_phase(16'd10, 16'd30, 4'd3, 27, 27, 50, 1'b0);
        write_reg(REG_SPARE, bdcc_pkg::CFG_W'($urandom));
        run_phase(16'd40, 16'd100, 4'd1, 0, 0, 40, 1'b0);
        run_phase(16'd15, 16'd45, 4'd0, 59, 0, 20, 1'b0);
        run_phase(16'd25, 16'd70, 4'd9, 0, 0, 60, 1'b1);
        for (p = 0; p < 4; p++) begin
            deb = ($urandom_range(3) == 0) ? bdcc_pkg::CFG_W'($urandom)
                                           : bdcc_pkg::CFG_W'($urandom_range(200));
            run_phase(deb, bdcc_pkg::CFG_W'(deb * $urandom_range(1, 4)),
                      bdcc_pkg::CNT_W'($urandom_range(15)),
                      idle_opts[p], stall_opts[p], 40, 1'b0);
        end

        repeat (4) @(posedge aclk);
        if (report_q.size() != 0)
            flag_mismatch("requests without result", report_q.size(), 0);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
